// ===== hw/rtl/udpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package udpr_pkg;

  localparam int MAX_PEERS_DEF = 64;

  localparam int PEER_W   = 6;
  localparam int BITMAP_W = 64;
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int ENTRY_W  = ADDR_W + PORT_W;
  localparam int CSUM_W   = 16;
  // Seven 16-bit header words summed without folding.
  localparam int PSUM_W   = 19;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 48;

  localparam logic [CFG_IW-1:0] CFG_FANOUT_ADDR = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_FANOUT_PORT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_GATEWAY_MAC = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_MAGIC       = 2'd3;

  localparam logic [31:0] CLONE_MARK = 32'h4d50_4943;
  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [3:0]  IHL_PLAIN  = 4'd5;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  localparam logic [1:0] VERDICT_PASS  = 2'd0;
  localparam logic [1:0] VERDICT_DROP  = 2'd1;
  localparam logic [1:0] VERDICT_CLONE = 2'd2;
  localparam logic [1:0] VERDICT_WRITE = 2'd3;

  localparam logic [1:0] KIND_PASS  = 2'd0;
  localparam logic [1:0] KIND_DROP  = 2'd1;
  localparam logic [1:0] KIND_REP   = 2'd2;
  localparam logic [1:0] KIND_WRITE = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  typedef struct packed {
    logic [1:0]          kind;
    logic [BITMAP_W-1:0] bitmap;
    logic [PSUM_W-1:0]   psum;
    logic                wr_ok;
    logic [PEER_W-1:0]   wr_idx;
    logic [ENTRY_W-1:0]  wr_data;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/udpr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface udpr_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] pkt_mark;
  logic        frame_long_enough;
  logic [15:0] ethertype;
  logic [31:0] ip_first_word;
  logic [47:0] ip_middle;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] udp_dst_port;
  logic [31:0] hdr_magic;
  logic [63:0] dest_bitmap;
  logic [5:0]  peer_index;

  modport source (
    output valid, req_type, pkt_mark, frame_long_enough, ethertype, ip_first_word,
           ip_middle, src_addr, dst_addr, udp_dst_port, hdr_magic, dest_bitmap,
           peer_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, pkt_mark, frame_long_enough, ethertype, ip_first_word,
           ip_middle, src_addr, dst_addr, udp_dst_port, hdr_magic, dest_bitmap,
           peer_index,
    output ready
  );
endinterface

interface udpr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [5:0]  clone_peer;
  logic [31:0] new_dst_addr;
  logic [15:0] new_dst_port;
  logic [15:0] new_ip_checksum;
  logic        last;

  modport source (
    output valid, verdict, clone_peer, new_dst_addr, new_dst_port, new_ip_checksum, last,
    input  ready
  );
  modport sink (
    input  valid, verdict, clone_peer, new_dst_addr, new_dst_port, new_ip_checksum, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/udp_broadcast_packet_replicator_top.sv =====
// Path: a pass, drop or table-write result goes through the command queue and the output
// register; a clone also passes the scan register, the peer RAM read and stage B.
// Throughput: the back end emits one clone per cycle from the peer RAM read port while the
// output is not stalled; single-result items go straight to the output register.
// Reset: synchronous, active low; control and config registers clear and every peer entry
// reads as zero until written, with per-entry valid bits cleared at once: no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module udp_broadcast_packet_replicator_top #(
  parameter int MAX_PEERS = udpr_pkg::MAX_PEERS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [udpr_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [udpr_pkg::CFG_DW-1:0] cfg_wdata,
  udpr_in_if.sink                          in_ch,
  udpr_out_if.source                       out_ch
);

  logic           push_valid;
  logic           push_ready;
  udpr_pkg::cmd_t push_cmd;
  logic           q_valid;
  logic           q_pop;
  udpr_pkg::cmd_t q_cmd;

  udpr_front #(
    .MAX_PEERS (MAX_PEERS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  udpr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  udpr_back #(
    .MAX_PEERS (MAX_PEERS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_cmd   (q_cmd),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/udpr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module udpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]               wdata,
  input  wire logic                           re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/udpr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module udpr_front #(
  parameter int MAX_PEERS = udpr_pkg::MAX_PEERS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [udpr_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [udpr_pkg::CFG_DW-1:0] cfg_wdata,
  udpr_in_if.sink                          in_ch,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output udpr_pkg::cmd_t                   push_cmd
);

  localparam logic [udpr_pkg::BITMAP_W-1:0] PEER_MASK =
    (MAX_PEERS >= udpr_pkg::BITMAP_W) ? {udpr_pkg::BITMAP_W{1'b1}} :
    ((udpr_pkg::BITMAP_W'(1) << MAX_PEERS) - udpr_pkg::BITMAP_W'(1));
  localparam logic [udpr_pkg::PEER_W:0] PEER_LIMIT = (udpr_pkg::PEER_W + 1)'(MAX_PEERS);

  logic [31:0] fanout_addr_r;
  logic [15:0] fanout_port_r;
  logic [31:0] magic_r;

  logic                            qualify;
  logic [udpr_pkg::BITMAP_W-1:0]   bitmap;
  logic [udpr_pkg::PSUM_W-1:0]     psum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fanout_addr_r <= '0;
      fanout_port_r <= '0;
      magic_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        udpr_pkg::CFG_FANOUT_ADDR: fanout_addr_r <= cfg_wdata[31:0];
        udpr_pkg::CFG_FANOUT_PORT: fanout_port_r <= cfg_wdata[15:0];
        // The gateway MAC is accepted but not stored by this block.
        udpr_pkg::CFG_GATEWAY_MAC: ;
        udpr_pkg::CFG_MAGIC:       magic_r       <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    qualify = (in_ch.pkt_mark != udpr_pkg::CLONE_MARK) &&
              in_ch.frame_long_enough &&
              (in_ch.ethertype == udpr_pkg::ETH_IPV4) &&
              (in_ch.ip_first_word[27:24] == udpr_pkg::IHL_PLAIN) &&
              (in_ch.ip_middle[7:0] == udpr_pkg::PROTO_UDP) &&
              (in_ch.dst_addr == fanout_addr_r) &&
              (in_ch.udp_dst_port == fanout_port_r) &&
              (in_ch.hdr_magic == magic_r);

    bitmap = in_ch.dest_bitmap & PEER_MASK;

    // Every header word except the destination address, which differs per clone.
    psum = udpr_pkg::PSUM_W'(in_ch.ip_first_word[31:16]) +
           udpr_pkg::PSUM_W'(in_ch.ip_first_word[15:0]) +
           udpr_pkg::PSUM_W'(in_ch.ip_middle[47:32]) +
           udpr_pkg::PSUM_W'(in_ch.ip_middle[31:16]) +
           udpr_pkg::PSUM_W'(in_ch.ip_middle[15:0]) +
           udpr_pkg::PSUM_W'(in_ch.src_addr[31:16]) +
           udpr_pkg::PSUM_W'(in_ch.src_addr[15:0]);

    push_cmd.bitmap  = bitmap;
    push_cmd.psum    = psum;
    push_cmd.wr_ok   = ({1'b0, in_ch.peer_index} < PEER_LIMIT);
    push_cmd.wr_idx  = in_ch.peer_index;
    push_cmd.wr_data = {in_ch.dst_addr, in_ch.udp_dst_port};

    if (in_ch.req_type) begin
      push_cmd.kind = udpr_pkg::KIND_WRITE;
    end else if (!qualify) begin
      push_cmd.kind = udpr_pkg::KIND_PASS;
    end else if (bitmap == '0) begin
      push_cmd.kind = udpr_pkg::KIND_DROP;
    end else begin
      push_cmd.kind = udpr_pkg::KIND_REP;
    end
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/udpr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module udpr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire udpr_pkg::cmd_t push_cmd,
  output logic                pop_valid,
  input  wire logic           pop,
  output udpr_pkg::cmd_t      pop_cmd
);

  localparam int AW = udpr_pkg::QUEUE_AW;

  udpr_pkg::cmd_t mem_r [udpr_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wp_r;
  logic [AW-1:0]  rp_r;
  logic [AW:0]    cnt_r;
  logic           do_push;

  assign push_ready = (cnt_r != (AW + 1)'(udpr_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + AW'(1);
      end
      if (do_push && !pop) begin
        cnt_r <= cnt_r + (AW + 1)'(1);
      end else if (pop && !do_push) begin
        cnt_r <= cnt_r - (AW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/udpr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module udpr_back #(
  parameter int MAX_PEERS = udpr_pkg::MAX_PEERS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  output logic                q_pop,
  input  wire udpr_pkg::cmd_t q_cmd,
  udpr_out_if.source          out_ch
);

  localparam int AW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int BW = udpr_pkg::BITMAP_W;
  localparam int PW = udpr_pkg::PEER_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  function automatic logic [PW-1:0] first_set(input logic [BW-1:0] v);
    logic [PW-1:0] r;
    r = '0;
    for (int i = BW - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = PW'(i);
      end
    end
    return r;
  endfunction

  logic                         state_r;
  logic [BW-1:0]                work_r;
  logic [udpr_pkg::PSUM_W-1:0]  psum_r;
  logic [MAX_PEERS-1:0]         peer_valid_r;

  logic                         b_valid_r;
  logic [PW-1:0]                b_idx_r;
  logic                         b_last_r;
  logic                         b_hit_r;

  logic                         out_valid_r;
  logic [1:0]                   verdict_r;
  logic [PW-1:0]                clone_peer_r;
  logic [31:0]                  dst_addr_r;
  logic [15:0]                  dst_port_r;
  logic [15:0]                  csum_r;
  logic                         last_r;

  logic                         out_free;
  logic                         b_move;
  logic                         b_free;
  logic [PW-1:0]                pick;
  logic [BW-1:0]                work_clr;
  logic                         pick_last;
  logic                         issue;
  logic                         is_rep;
  logic                         single;
  logic                         ram_we;
  logic [udpr_pkg::ENTRY_W-1:0] ram_rdata;
  logic [udpr_pkg::ENTRY_W-1:0] entry;
  logic [20:0]                  sum_a;
  logic [16:0]                  sum_b;
  logic [15:0]                  sum_c;
  logic [1:0]                   single_verdict;

  always_comb begin
    out_free  = !out_valid_r || out_ch.ready;
    b_move    = b_valid_r && out_free;
    b_free    = !b_valid_r || b_move;
    pick      = first_set(work_r);
    work_clr  = work_r & (work_r - BW'(1));
    pick_last = (work_clr == '0);
    issue     = (state_r == ST_SCAN) && b_free;
    is_rep    = (q_cmd.kind == udpr_pkg::KIND_REP);
    // A new command waits until the last clone of the previous frame has left stage B.
    q_pop     = (state_r == ST_IDLE) && q_valid && !b_valid_r && (is_rep || out_free);
    single    = q_pop && !is_rep;
    ram_we    = q_pop && (q_cmd.kind == udpr_pkg::KIND_WRITE) && q_cmd.wr_ok;

    // A peer never written since reset reads as zero.
    entry = b_hit_r ? ram_rdata : '0;
    sum_a = 21'(psum_r) + 21'(entry[47:32]) + 21'(entry[31:16]);
    sum_b = 17'(sum_a[15:0]) + 17'(sum_a[20:16]);
    sum_c = sum_b[15:0] + 16'(sum_b[16]);

    case (q_cmd.kind)
      udpr_pkg::KIND_WRITE: single_verdict = udpr_pkg::VERDICT_WRITE;
      udpr_pkg::KIND_DROP:  single_verdict = udpr_pkg::VERDICT_DROP;
      default:              single_verdict = udpr_pkg::VERDICT_PASS;
    endcase
  end

  udpr_ram #(
    .WIDTH (udpr_pkg::ENTRY_W),
    .DEPTH (MAX_PEERS)
  ) u_peer_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_cmd.wr_idx[AW-1:0]),
    .wdata (q_cmd.wr_data),
    .re    (issue),
    .raddr (pick[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      b_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      peer_valid_r <= '0;
    end else begin
      if (ram_we) begin
        peer_valid_r[q_cmd.wr_idx[AW-1:0]] <= 1'b1;
      end

      if (q_pop && is_rep) begin
        state_r <= ST_SCAN;
      end else if (issue && pick_last) begin
        state_r <= ST_IDLE;
      end

      if (issue) begin
        b_valid_r <= 1'b1;
      end else if (b_move) begin
        b_valid_r <= 1'b0;
      end

      if (single || b_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && is_rep) begin
      work_r <= q_cmd.bitmap;
      psum_r <= q_cmd.psum;
    end else if (issue) begin
      work_r <= work_clr;
    end

    if (issue) begin
      b_idx_r  <= pick;
      b_last_r <= pick_last;
      b_hit_r  <= peer_valid_r[pick[AW-1:0]];
    end

    if (single) begin
      verdict_r    <= single_verdict;
      clone_peer_r <= '0;
      dst_addr_r   <= '0;
      dst_port_r   <= '0;
      csum_r       <= '0;
      last_r       <= 1'b1;
    end else if (b_move) begin
      verdict_r    <= udpr_pkg::VERDICT_CLONE;
      clone_peer_r <= b_idx_r;
      dst_addr_r   <= entry[47:16];
      dst_port_r   <= entry[15:0];
      csum_r       <= ~sum_c;
      last_r       <= b_last_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.verdict         = verdict_r;
  assign out_ch.clone_peer      = clone_peer_r;
  assign out_ch.new_dst_addr    = dst_addr_r;
  assign out_ch.new_dst_port    = dst_port_r;
  assign out_ch.new_ip_checksum = csum_r;
  assign out_ch.last            = last_r;

endmodule

`default_nettype wire

// ===== tb/udp_broadcast_packet_replicator_top_test.sv =====
`timescale 1ns / 1ps

module udp_broadcast_packet_replicator_top_test;

  localparam int NUM_PEERS   = udpr_pkg::MAX_PEERS_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;

  typedef struct packed {
    bit        is_write;
    bit [31:0] mark;
    bit        long_ok;
    bit [15:0] etype;
    bit [31:0] first_word;
    bit [47:0] middle;
    bit [31:0] src;
    bit [31:0] dst;
    bit [15:0] port;
    bit [31:0] magic;
    bit [63:0] bitmap;
    bit [5:0]  index;
  } pkt_desc_t;

  typedef struct packed {
    bit [1:0]  verdict;
    bit [5:0]  peer;
    bit [31:0] addr;
    bit [15:0] port;
    bit [15:0] csum;
    bit        last;
  } fanout_res_t;

  class replica_scoreboard;
    bit [47:0]   peer_entry [NUM_PEERS];
    bit [31:0]   fan_addr;
    bit [15:0]   fan_port;
    bit [47:0]   gw_mac;
    bit [31:0]   want_magic;
    fanout_res_t pending_q [$];
    int          mismatches;
    int          frames;
    int          writes;
    int          results;
    int          clones;

    function new();
      foreach (peer_entry[i]) peer_entry[i] = '0;
      fan_addr   = '0;
      fan_port   = '0;
      gw_mac     = '0;
      want_magic = '0;
      mismatches = 0;
      frames     = 0;
      writes     = 0;
      results    = 0;
      clones     = 0;
    endfunction

    function void write_reg(logic [udpr_pkg::CFG_IW-1:0] idx,
                            logic [udpr_pkg::CFG_DW-1:0] val);
      case (idx)
        udpr_pkg::CFG_FANOUT_ADDR: fan_addr = val[31:0];
        udpr_pkg::CFG_FANOUT_PORT: fan_port = val[15:0];
        udpr_pkg::CFG_GATEWAY_MAC: gw_mac = val;
        udpr_pkg::CFG_MAGIC:       want_magic = val[31:0];
        default: ;
      endcase
    endfunction

    // Ones' complement of the ones' complement sum of the header words, with the checksum field taken as zero.
    function bit [15:0] header_csum(bit [31:0] w0, bit [47:0] mid, bit [31:0] sa,
                                    bit [31:0] da);
      int unsigned acc;
      acc = 0;
      acc += w0[31:16];
      acc += w0[15:0];
      acc += mid[47:32];
      acc += mid[31:16];
      acc += mid[15:0];
      acc += sa[31:16];
      acc += sa[15:0];
      acc += da[31:16];
      acc += da[15:0];
      while ((acc >> 16) != 0) acc = (acc & 32'hFFFF) + (acc >> 16);
      return ~acc[15:0];
    endfunction

    function bit qualifies(pkt_desc_t p);
      return p.mark != udpr_pkg::CLONE_MARK && p.long_ok &&
             p.etype == udpr_pkg::ETH_IPV4 &&
             p.first_word[27:24] == udpr_pkg::IHL_PLAIN &&
             p.middle[7:0] == udpr_pkg::PROTO_UDP &&
             p.dst == fan_addr && p.port == fan_port && p.magic == want_magic;
    endfunction

    function void note_input(pkt_desc_t p);
      fanout_res_t r;
      int          top;
      r = '0;
      r.last = 1'b1;
      if (p.is_write) begin
        writes++;
        if (p.index < NUM_PEERS) peer_entry[p.index] = {p.dst, p.port};
        r.verdict = udpr_pkg::VERDICT_WRITE;
        pending_q.push_back(r);
        return;
      end
      frames++;
      if (!qualifies(p)) begin
        r.verdict = udpr_pkg::VERDICT_PASS;
        pending_q.push_back(r);
        return;
      end
      top = -1;
      for (int i = 0; i < NUM_PEERS; i++) if (p.bitmap[i]) top = i;
      if (top < 0) begin
        r.verdict = udpr_pkg::VERDICT_DROP;
        pending_q.push_back(r);
        return;
      end
      for (int i = 0; i <= top; i++) begin
        if (p.bitmap[i]) begin
          r.verdict = udpr_pkg::VERDICT_CLONE;
          r.peer    = 6'(i);
          r.addr    = peer_entry[i][47:16];
          r.port    = peer_entry[i][15:0];
          r.csum    = header_csum(p.first_word, p.middle, p.src, r.addr);
          r.last    = (i == top);
          pending_q.push_back(r);
        end
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 100) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_result(fanout_res_t got);
      fanout_res_t want;
      string       diffs;
      results++;
      if (got.verdict == udpr_pkg::VERDICT_CLONE) clones++;
      if (pending_q.size() == 0) begin
        report($sformatf("result beat with nothing outstanding: verdict %0d peer %0d",
                         got.verdict, got.peer));
        return;
      end
      want = pending_q.pop_front();
      diffs = "";
      if (got.verdict != want.verdict)
        diffs = {diffs, $sformatf(" verdict %0d/%0d", got.verdict, want.verdict)};
      if (got.peer != want.peer)
        diffs = {diffs, $sformatf(" peer %0d/%0d", got.peer, want.peer)};
      if (got.addr != want.addr)
        diffs = {diffs, $sformatf(" addr %h/%h", got.addr, want.addr)};
      if (got.port != want.port)
        diffs = {diffs, $sformatf(" port %h/%h", got.port, want.port)};
      if (got.csum != want.csum)
        diffs = {diffs, $sformatf(" csum %h/%h", got.csum, want.csum)};
      if (got.last != want.last)
        diffs = {diffs, $sformatf(" last %0d/%0d", got.last, want.last)};
      if (diffs != "") report({"result mismatch (got/wanted):", diffs});
    endtask
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [udpr_pkg::CFG_IW-1:0] cfg_index;
  logic [udpr_pkg::CFG_DW-1:0] cfg_wdata;

  udpr_in_if  in_ch ();
  udpr_out_if out_ch ();

  udp_broadcast_packet_replicator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  replica_scoreboard sb;
  bit                hold_req;
  int                src_run;
  int                sink_run;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly random gaps, with the odd run of back-to-back beats.
  function automatic int draw_wait(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      run = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  task automatic write_cfg(logic [udpr_pkg::CFG_IW-1:0] idx,
                           logic [udpr_pkg::CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(bit [31:0] addr, bit [15:0] port, bit [47:0] mac,
                            bit [31:0] magic);
    write_cfg(udpr_pkg::CFG_FANOUT_ADDR, udpr_pkg::CFG_DW'(addr));
    write_cfg(udpr_pkg::CFG_FANOUT_PORT, udpr_pkg::CFG_DW'(port));
    write_cfg(udpr_pkg::CFG_GATEWAY_MAC, mac);
    write_cfg(udpr_pkg::CFG_MAGIC, udpr_pkg::CFG_DW'(magic));
  endtask

  task automatic send_pkt(pkt_desc_t p);
    int gap;
    gap = draw_wait(src_run);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.req_type          = p.is_write;
    in_ch.pkt_mark          = p.mark;
    in_ch.frame_long_enough = p.long_ok;
    in_ch.ethertype         = p.etype;
    in_ch.ip_first_word     = p.first_word;
    in_ch.ip_middle         = p.middle;
    in_ch.src_addr          = p.src;
    in_ch.dst_addr          = p.dst;
    in_ch.udp_dst_port      = p.port;
    in_ch.hdr_magic         = p.magic;
    in_ch.dest_bitmap       = p.bitmap;
    in_ch.peer_index        = p.index;
    in_ch.valid             = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_input(p);
  endtask

  // Stop offering and wait until the block has nothing left to deliver.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic pkt_desc_t good_frame(bit [63:0] bitmap);
    pkt_desc_t p;
    p.is_write   = 1'b0;
    p.mark       = $urandom;
    if (p.mark == udpr_pkg::CLONE_MARK) p.mark[0] = ~p.mark[0];
    p.long_ok    = 1'b1;
    p.etype      = udpr_pkg::ETH_IPV4;
    p.first_word = $urandom;
    p.first_word[27:24] = udpr_pkg::IHL_PLAIN;
    p.middle     = {16'($urandom), 32'($urandom)};
    p.middle[7:0] = udpr_pkg::PROTO_UDP;
    p.src        = $urandom;
    p.dst        = sb.fan_addr;
    p.port       = sb.fan_port;
    p.magic      = sb.want_magic;
    p.bitmap     = bitmap;
    p.index      = 6'($urandom);
    return p;
  endfunction

  function automatic pkt_desc_t peer_write(bit [5:0] idx, bit [31:0] addr, bit [15:0] port);
    pkt_desc_t p;
    p          = good_frame({$urandom, $urandom});
    p.is_write = 1'b1;
    p.mark     = $urandom;
    p.long_ok  = 1'($urandom);
    p.etype    = 16'($urandom);
    p.magic    = $urandom;
    p.dst      = addr;
    p.port     = port;
    p.index    = idx;
    return p;
  endfunction

  function automatic bit [63:0] random_bitmap();
    bit [63:0] b;
    b = '0;
    case ($urandom_range(0, 19))
      0:       b = '1;
      1, 2:    b = '0;
      3, 4, 5: b = {$urandom, $urandom};
      default: repeat ($urandom_range(1, 4)) b[$urandom_range(0, 63)] = 1'b1;
    endcase
    return b;
  endfunction

  // A well-formed frame with exactly one reason to be left alone.
  function automatic pkt_desc_t broken_frame();
    pkt_desc_t p;
    p = good_frame(random_bitmap());
    case ($urandom_range(0, 7))
      0: p.mark = udpr_pkg::CLONE_MARK;
      1: p.long_ok = 1'b0;
      2: begin
        p.etype = 16'($urandom);
        if (p.etype == udpr_pkg::ETH_IPV4) p.etype[15] = 1'b1;
      end
      3: begin
        p.first_word[27:24] = 4'($urandom);
        if (p.first_word[27:24] == udpr_pkg::IHL_PLAIN) p.first_word[24] = 1'b0;
      end
      4: begin
        p.middle[7:0] = 8'($urandom);
        if (p.middle[7:0] == udpr_pkg::PROTO_UDP) p.middle[7] = 1'b1;
      end
      5: p.dst = p.dst ^ (32'd1 << $urandom_range(0, 31));
      6: p.port = p.port ^ (16'd1 << $urandom_range(0, 15));
      default: p.magic = p.magic ^ (32'd1 << $urandom_range(0, 31));
    endcase
    return p;
  endfunction

  function automatic pkt_desc_t random_item();
    pkt_desc_t p;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      p = good_frame(random_bitmap());
    end else if (pick < 70) begin
      p = broken_frame();
    end else if (pick < 80) begin
      p = peer_write(6'($urandom), $urandom, 16'($urandom));
      p.is_write = 1'b0;
    end else begin
      p = peer_write(6'($urandom), $urandom, 16'($urandom));
    end
    return p;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_pkt(random_item());
  endtask

  initial begin : result_sink
    int          w;
    fanout_res_t got;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // Long back-pressure so that the block fills and stalls its input.
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        w = draw_wait(sink_run);
        if (w > 0) begin
          out_ch.ready = 1'b0;
          repeat (w) @(negedge clk);
        end
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.verdict = out_ch.verdict;
      got.peer    = out_ch.clone_peer;
      got.addr    = out_ch.new_dst_addr;
      got.port    = out_ch.new_dst_port;
      got.csum    = out_ch.new_ip_checksum;
      got.last    = out_ch.last;
      sb.check_result(got);
    end
  end

  initial begin
    #5ms;
    $display("Run timed out with %0d results outstanding.", sb.pending_q.size());
    $display("udp_broadcast_packet_replicator_top verification failed");
    $finish;
  end

  initial begin
    pkt_desc_t p;
    sb        = new();
    clk       = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_req  = 1'b0;
    src_run   = 0;
    sink_run  = 0;
    in_ch.valid             = 1'b0;
    in_ch.req_type          = 1'b0;
    in_ch.pkt_mark          = '0;
    in_ch.frame_long_enough = 1'b0;
    in_ch.ethertype         = '0;
    in_ch.ip_first_word     = '0;
    in_ch.ip_middle         = '0;
    in_ch.src_addr          = '0;
    in_ch.dst_addr          = '0;
    in_ch.udp_dst_port      = '0;
    in_ch.hdr_magic         = '0;
    in_ch.dest_bitmap       = '0;
    in_ch.peer_index        = '0;
    out_ch.ready            = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_config(32'hC0A8_01FF, 16'd7400, 48'h0200_5E00_0001, 32'h1234_ABCD);

    send_pkt(peer_write(6'd0, 32'hFFFF_FFFF, 16'hFFFF));
    send_pkt(peer_write(6'd63, 32'h0A00_0001, 16'h0001));
    send_pkt(peer_write(6'd31, 32'h8000_0000, 16'h8000));
    send_pkt(good_frame(64'h1));
    send_pkt(good_frame(64'h8000_0000_8000_0001));
    send_pkt(good_frame(64'h0));
    // Every peer, most of them never written and so still zero.
    send_pkt(good_frame('1));
    // Header words at their extremes exercise the end-around carry.
    p = good_frame(64'h8000_0000_0000_0001);
    p.first_word = 32'hF5FF_FFFF;
    p.middle     = 48'hFFFF_FFFF_FF11;
    p.src        = '1;
    send_pkt(p);
    p = good_frame(64'h1);
    p.mark       = '0;
    p.first_word = 32'h0500_0000;
    p.middle     = 48'h0000_0000_0011;
    p.src        = '0;
    send_pkt(p);
    p = good_frame(64'h1);
    p.mark = udpr_pkg::CLONE_MARK ^ 32'd1;
    send_pkt(p);
    p = good_frame(64'h1);
    p.mark = udpr_pkg::CLONE_MARK;
    send_pkt(p);
    p = good_frame(64'h1);
    p.long_ok = 1'b0;
    send_pkt(p);
    p = good_frame(64'h1);
    p.etype = 16'h86DD;
    send_pkt(p);
    p = good_frame(64'h1);
    p.first_word[27:24] = 4'd4;
    send_pkt(p);
    p = good_frame(64'h1);
    p.first_word[27:24] = 4'hF;
    send_pkt(p);
    p = good_frame(64'h1);
    p.middle[7:0] = 8'd6;
    send_pkt(p);
    p = good_frame(64'h1);
    p.dst = p.dst ^ 32'd1;
    send_pkt(p);
    p = good_frame(64'h1);
    p.port = p.port ^ 16'd1;
    send_pkt(p);
    p = good_frame(64'h1);
    p.magic = p.magic ^ 32'h8000_0000;
    send_pkt(p);
    send_pkt(peer_write(6'd0, 32'h0102_0304, 16'd9000));
    send_pkt(good_frame(64'h1));
    drain();

    run_random(30);
    drain();

    set_config('1, '1, '1, '1);
    hold_req = 1'b1;
    run_random(15);
    drain();
    run_random(15);
    drain();

    set_config('0, '0, '0, '0);
    run_random(30);
    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d frames and %0d peer table writes under three register settings,",
             sb.frames, sb.writes);
    $display("including a long output stall; %0d result beats checked, %0d of them clones.",
             sb.results, sb.clones);
    if (sb.mismatches == 0) begin
      $display("udp_broadcast_packet_replicator_top verification clean");
    end else begin
      $display("%0d mismatches found.", sb.mismatches);
      $display("udp_broadcast_packet_replicator_top verification failed");
    end
    $finish;
  end

endmodule
